### rtl/core/nspc_pkg.sv
`timescale 1ns / 1ps
// shared types and fixed widths for the nearest-site pixel color core
// no dependencies
package nspc_pkg;

  localparam int IDX_W   = 6;   // site index field and nearest index
  localparam int COUNT_W = 7;   // site count register
  localparam int CHAN_W  = 8;   // one color channel
  localparam int COLOR_W = 3 * CHAN_W;

  // control bits that ride along with each word through the chain
  typedef struct packed {
    logic valid;
    logic query;   // 1 query a pixel, 0 load a site
    logic found;   // some site already matched this query
  } ctrl_t;

endpackage

### rtl/core/nspc_cell.sv
`timescale 1ns / 1ps
// one chain cell: holds one site, computes the squared distance, keeps the best
// depends on nspc_pkg
module nspc_cell #(
  parameter int I       = 0,
  parameter int COORD_W = 10,
  parameter int DIST_W  = 21
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [nspc_pkg::COUNT_W-1:0] site_count,
  input  nspc_pkg::ctrl_t              ctrl_in,
  input  logic [nspc_pkg::IDX_W-1:0]   idx_in,
  input  logic [COORD_W-1:0]           x_in,
  input  logic [COORD_W-1:0]           y_in,
  input  logic [nspc_pkg::COLOR_W-1:0] rgb_in,
  input  logic [DIST_W-1:0]            dist_in,
  output nspc_pkg::ctrl_t              ctrl_out,
  output logic [nspc_pkg::IDX_W-1:0]   idx_out,
  output logic [COORD_W-1:0]           x_out,
  output logic [COORD_W-1:0]           y_out,
  output logic [nspc_pkg::COLOR_W-1:0] rgb_out,
  output logic [DIST_W-1:0]            dist_out
);

  // site entry
  logic [COORD_W-1:0]           sx;
  logic [COORD_W-1:0]           sy;
  logic [nspc_pkg::COLOR_W-1:0] scol;

  // first stage: distance
  nspc_pkg::ctrl_t              a_ctrl;
  logic [nspc_pkg::IDX_W-1:0]   a_idx;
  logic [COORD_W-1:0]           a_x;
  logic [COORD_W-1:0]           a_y;
  logic [nspc_pkg::COLOR_W-1:0] a_rgb;
  logic [DIST_W-1:0]            a_best;
  logic [DIST_W-1:0]            a_d;

  logic [COORD_W-1:0]   dx;
  logic [COORD_W-1:0]   dy;
  logic [2*COORD_W-1:0] dx2;
  logic [2*COORD_W-1:0] dy2;
  logic [DIST_W-1:0]    d_next;
  logic                 wr;
  logic                 active;
  logic                 take;

  assign wr     = en && ctrl_in.valid && !ctrl_in.query && (int'(idx_in) == I);
  assign dx     = (x_in >= sx) ? (x_in - sx) : (sx - x_in);
  assign dy     = (y_in >= sy) ? (y_in - sy) : (sy - y_in);
  assign dx2    = dx * dx;
  assign dy2    = dy * dy;
  assign d_next = DIST_W'(dx2) + DIST_W'(dy2);

  always_ff @(posedge clk) begin
    if (wr) begin
      sx   <= x_in;
      sy   <= y_in;
      scol <= rgb_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctrl <= '0;
    end else if (en) begin
      a_ctrl <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_idx  <= idx_in;
      a_x    <= x_in;
      a_y    <= y_in;
      a_rgb  <= rgb_in;
      a_best <= dist_in;
      a_d    <= d_next;
    end
  end

  // second stage: compare, earlier site wins a tie
  assign active = int'(site_count) > I;
  assign take   = a_ctrl.query && active && (!a_ctrl.found || (a_d < a_best));

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out.valid <= a_ctrl.valid;
      ctrl_out.query <= a_ctrl.query;
      ctrl_out.found <= a_ctrl.found || take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= a_x;
      y_out    <= a_y;
      idx_out  <= take ? nspc_pkg::IDX_W'(I) : a_idx;
      rgb_out  <= take ? scol : a_rgb;
      dist_out <= take ? a_d : a_best;
    end
  end

endmodule

### rtl/core/nearest_site_pixel_color_core.sv
`timescale 1ns / 1ps
// top level of the nearest-site pixel color core: chain of site cells
// depends on nspc_pkg and nspc_cell
// two register levels per cell plus the result register lie between a word's input and its result
// throughput: one word per cycle, the chain shifts on every cycle with no held result
// a held result stalls the whole chain until it is taken
// reset clears word valids and site_count; site entries are not cleared
module nearest_site_pixel_color_core #(
  parameter  int MAX_SITES  = 64,
  parameter  int IMAGE_SIDE = 1024,
  localparam int COORD_W    = $clog2(IMAGE_SIDE),
  localparam int DIST_W     = 2 * COORD_W + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  // site count register
  input  logic                         site_count_we,
  input  logic [nspc_pkg::COUNT_W-1:0] site_count_wdata,
  // input words
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic [nspc_pkg::IDX_W-1:0]   site_index,
  input  logic [COORD_W-1:0]           coord_x,
  input  logic [COORD_W-1:0]           coord_y,
  input  logic [nspc_pkg::CHAN_W-1:0]  red_in,
  input  logic [nspc_pkg::CHAN_W-1:0]  green_in,
  input  logic [nspc_pkg::CHAN_W-1:0]  blue_in,
  // result words
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [COORD_W-1:0]           pixel_x,
  output logic [COORD_W-1:0]           pixel_y,
  output logic [nspc_pkg::CHAN_W-1:0]  red_out,
  output logic [nspc_pkg::CHAN_W-1:0]  green_out,
  output logic [nspc_pkg::CHAN_W-1:0]  blue_out,
  output logic                         site_found,
  output logic [nspc_pkg::IDX_W-1:0]   nearest_index
);

  localparam int CW      = nspc_pkg::CHAN_W;

  logic [nspc_pkg::COUNT_W-1:0] site_count;

  // chain lanes, entry 0 is the input side, entry MAX_SITES leaves the last cell
  nspc_pkg::ctrl_t              ctrl_c [0:MAX_SITES];
  logic [nspc_pkg::IDX_W-1:0]   idx_c  [0:MAX_SITES];
  logic [COORD_W-1:0]           x_c    [0:MAX_SITES];
  logic [COORD_W-1:0]           y_c    [0:MAX_SITES];
  logic [nspc_pkg::COLOR_W-1:0] rgb_c  [0:MAX_SITES];
  logic [DIST_W-1:0]            dist_c [0:MAX_SITES];

  logic en;
  logic out_valid_next;
  logic last_query;

  // the chain moves whenever the output register is free or being drained
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      site_count <= '0;
    end else if (site_count_we) begin
      site_count <= site_count_wdata;
    end
  end

  // a load word carries its index and color down the chain; a query starts
  // with nothing found, zero color and zero index so an empty search reads 0
  assign ctrl_c[0].valid = in_valid && in_ready;
  assign ctrl_c[0].query = func;
  assign ctrl_c[0].found = 1'b0;
  assign idx_c[0]        = func ? '0 : site_index;
  assign x_c[0]          = coord_x;
  assign y_c[0]          = coord_y;
  assign rgb_c[0]        = func ? '0 : {red_in, green_in, blue_in};
  assign dist_c[0]       = '0;

  // one cell per site; loads ride the same chain as queries so that every
  // query sees exactly the loads accepted before it
  for (genvar g = 0; g < MAX_SITES; g++) begin : g_cell
    nspc_cell #(
      .I       (g),
      .COORD_W (COORD_W),
      .DIST_W  (DIST_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .site_count (site_count),
      .ctrl_in    (ctrl_c[g]),
      .idx_in     (idx_c[g]),
      .x_in       (x_c[g]),
      .y_in       (y_c[g]),
      .rgb_in     (rgb_c[g]),
      .dist_in    (dist_c[g]),
      .ctrl_out   (ctrl_c[g+1]),
      .idx_out    (idx_c[g+1]),
      .x_out      (x_c[g+1]),
      .y_out      (y_c[g+1]),
      .rgb_out    (rgb_c[g+1]),
      .dist_out   (dist_c[g+1])
    );
  end

  // only queries make a result; loads drop off at the end of the chain
  assign last_query     = ctrl_c[MAX_SITES].valid && ctrl_c[MAX_SITES].query;
  assign out_valid_next = en ? last_query : out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      pixel_x       <= x_c[MAX_SITES];
      pixel_y       <= y_c[MAX_SITES];
      red_out       <= rgb_c[MAX_SITES][3*CW-1:2*CW];
      green_out     <= rgb_c[MAX_SITES][2*CW-1:CW];
      blue_out      <= rgb_c[MAX_SITES][CW-1:0];
      site_found    <= ctrl_c[MAX_SITES].found;
      nearest_index <= idx_c[MAX_SITES];
    end
  end

  // an empty search gives an all-zero color and index
  a_empty_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !site_found |->
      red_out == '0 && green_out == '0 && blue_out == '0 && nearest_index == '0)
    else $error("empty search result not zero");

  // with no sites in use nothing can be found
  a_none_found : assert property (@(posedge clk) disable iff (rst)
    out_valid && site_count == '0 |-> !site_found)
    else $error("site found with zero site count");

  // with sites in use some site always wins
  a_some_found : assert property (@(posedge clk) disable iff (rst)
    out_valid && site_count != '0 |-> site_found)
    else $error("no site found with nonzero site count");

  // input side only stalls behind a held result
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

endmodule

### test/tb_nearest_site_pixel_color_core.sv
`timescale 1ns / 1ps
// self-checking testbench for nearest_site_pixel_color_core: site loads, pixel queries,
// site-count changes; depends on nspc_pkg and the core rtl
module tb_nearest_site_pixel_color_core;

  localparam int IDX_W        = nspc_pkg::IDX_W;
  localparam int COUNT_W      = nspc_pkg::COUNT_W;
  localparam int CHAN_W       = nspc_pkg::CHAN_W;
  localparam int COLOR_W      = nspc_pkg::COLOR_W;
  localparam int MAX_SITES    = 64;
  localparam int COORD_W      = 10;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;
  // loads give no result word, so after the last result we still let a load pass
  // through the chain before touching site_count
  localparam int DRAIN_CYCLES = 2 * MAX_SITES + 1 + 16;
  // longest quiet stretch in a correct run is a drain wait, well below this
  localparam int IDLE_LIMIT   = 4000;
  localparam int CLUSTER_BASE = 504;   // crowded patch of sites, gives many exact ties
  localparam int PHASE_WORDS  = 120;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef struct packed {
    func_e              func;
    logic [IDX_W-1:0]   site_index;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
  } site_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  red_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  blue_out;
    logic               site_found;
    logic [IDX_W-1:0]   nearest_index;
  } pixel_result_t;

  // own copy of the site table; every query word accepted turns into one
  // expected pixel color, kept in order until the core hands it back
  class pixel_color_scoreboard;
    logic [COORD_W-1:0] site_x [MAX_SITES];
    logic [COORD_W-1:0] site_y [MAX_SITES];
    logic [COLOR_W-1:0] site_rgb [MAX_SITES];
    logic [COUNT_W-1:0] active_count;
    pixel_result_t      pending_colors [$];
    int                 mismatches;
    int                 results_seen;
    int                 empty_results;

    function new();
      active_count  = '0;
      mismatches    = 0;
      results_seen  = 0;
      empty_results = 0;
    endfunction

    function void set_count(logic [COUNT_W-1:0] n);
      active_count = n;
    endfunction

    function int pending();
      return pending_colors.size();
    endfunction

    // exact squared distance to every active site, first minimum wins ties
    function pixel_result_t nearest_site_lookup(logic [COORD_W-1:0] px,
                                                logic [COORD_W-1:0] py);
      pixel_result_t r;
      int unsigned   span, dx, dy, range_sq, best_sq;
      int            i;
      r = '0;
      r.pixel_x = px;
      r.pixel_y = py;
      best_sq = 0;
      span = (active_count > MAX_SITES) ? MAX_SITES : active_count;
      for (i = 0; i < span; i++) begin
        dx = (px > site_x[i]) ? px - site_x[i] : site_x[i] - px;
        dy = (py > site_y[i]) ? py - site_y[i] : site_y[i] - py;
        range_sq = dx * dx + dy * dy;
        if (!r.site_found || range_sq < best_sq) begin
          r.site_found    = 1'b1;
          best_sq         = range_sq;
          r.nearest_index = IDX_W'(i);
          {r.red_out, r.green_out, r.blue_out} = site_rgb[i];
        end
      end
      return r;
    endfunction

    function void note_word(site_word_t w);
      if (w.func == FUNC_LOAD) begin
        site_x[w.site_index]   = w.coord_x;
        site_y[w.site_index]   = w.coord_y;
        site_rgb[w.site_index] = {w.red, w.green, w.blue};
      end else begin
        pending_colors.insert(pending_colors.size(),
                              nearest_site_lookup(w.coord_x, w.coord_y));
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (pending_colors.size() == 0) begin
        $error("unexpected result word at pixel (%0d,%0d)", got.pixel_x, got.pixel_y);
        mismatches++;
        return;
      end
      want = pending_colors.pop_front();
      results_seen++;
      if (!want.site_found) empty_results++;
      check_field("pixel_x", want.pixel_x, got.pixel_x);
      check_field("pixel_y", want.pixel_y, got.pixel_y);
      check_field("red_out", want.red_out, got.red_out);
      check_field("green_out", want.green_out, got.green_out);
      check_field("blue_out", want.blue_out, got.blue_out);
      check_field("site_found", want.site_found, got.site_found);
      check_field("nearest_index", want.nearest_index, got.nearest_index);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                site_count_we;
  logic [COUNT_W-1:0]  site_count_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                func;
  logic [IDX_W-1:0]    site_index;
  logic [COORD_W-1:0]  coord_x;
  logic [COORD_W-1:0]  coord_y;
  logic [CHAN_W-1:0]   red_in;
  logic [CHAN_W-1:0]   green_in;
  logic [CHAN_W-1:0]   blue_in;
  logic                out_valid;
  logic                out_ready;
  logic [COORD_W-1:0]  pixel_x;
  logic [COORD_W-1:0]  pixel_y;
  logic [CHAN_W-1:0]   red_out;
  logic [CHAN_W-1:0]   green_out;
  logic [CHAN_W-1:0]   blue_out;
  logic                site_found;
  logic [IDX_W-1:0]    nearest_index;

  pixel_color_scoreboard sb;
  bit                    sender_burst;     // no gaps between input words
  bit                    receiver_burst;   // no stalls on result words
  int                    sent_loads;
  int                    sent_queries;
  int                    count_settings;
  int                    quiet_cycles;

  always #5 clk = ~clk;

  nearest_site_pixel_color_core #(
    .MAX_SITES (MAX_SITES),
    .IMAGE_SIDE(1024)
  ) uut (
    .clk             (clk),
    .rst             (rst),
    .site_count_we   (site_count_we),
    .site_count_wdata(site_count_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .site_index      (site_index),
    .coord_x         (coord_x),
    .coord_y         (coord_y),
    .red_in          (red_in),
    .green_in        (green_in),
    .blue_in         (blue_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .red_out         (red_out),
    .green_out       (green_out),
    .blue_out        (blue_out),
    .site_found      (site_found),
    .nearest_index   (nearest_index)
  );

  // watchdog: a run that stops moving words for too long is a hang
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic site_word_t make_load(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] x,
                                           logic [COORD_W-1:0] y, logic [CHAN_W-1:0] r,
                                           logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
    site_word_t w;
    w.func       = FUNC_LOAD;
    w.site_index = idx;
    w.coord_x    = x;
    w.coord_y    = y;
    w.red        = r;
    w.green      = g;
    w.blue       = b;
    return w;
  endfunction

  // query words carry random junk in the load-only fields, the core must ignore it
  function automatic site_word_t make_query(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    site_word_t w;
    w = make_load(IDX_W'($urandom), x, y, CHAN_W'($urandom), CHAN_W'($urandom),
                  CHAN_W'($urandom));
    w.func = FUNC_QUERY;
    return w;
  endfunction

  // sometimes the image edges, else the crowded patch when clustered, else the full range
  function automatic logic [COORD_W-1:0] pick_coord(bit clustered);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return ($urandom_range(0, 1) != 0) ? COORD_W'(COORD_MAX) : '0;
    if (clustered) return COORD_W'(CLUSTER_BASE + $urandom_range(0, 15));
    return COORD_W'($urandom_range(0, COORD_MAX));
  endfunction

  // present one word; valid stays up from the first cycle until the handshake
  task automatic send_word(site_word_t w);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= w.func;
    site_index <= w.site_index;
    coord_x    <= w.coord_x;
    coord_y    <= w.coord_y;
    red_in     <= w.red;
    green_in   <= w.green;
    blue_in    <= w.blue;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    if (w.func == FUNC_LOAD) sent_loads++;
    else sent_queries++;
  endtask

  // site_count only changes with the chain empty: results drained, then loads flushed
  task automatic set_site_count(logic [COUNT_W-1:0] n);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    site_count_we    <= 1'b1;
    site_count_wdata <= n;
    @(posedge clk);
    site_count_we <= 1'b0;
    sb.set_count(n);
    count_settings++;
  endtask

  // random phase: queries with loads mixed in; every entry is loaded by now,
  // so any site count keeps the search inside written entries
  task automatic run_phase(logic [COUNT_W-1:0] n, bit clustered);
    set_site_count(n);
    sender_burst   = ($urandom_range(0, 3) == 0);
    receiver_burst = ($urandom_range(0, 3) == 0);
    repeat (PHASE_WORDS) begin
      if ($urandom_range(0, 3) == 0)
        send_word(make_load(IDX_W'($urandom_range(0, MAX_SITES - 1)), pick_coord(clustered),
                            pick_coord(clustered), CHAN_W'($urandom), CHAN_W'($urandom),
                            CHAN_W'($urandom)));
      else
        send_word(make_query(pick_coord(clustered), pick_coord(clustered)));
    end
  endtask

  // result side: random stall per word, ready held until a word is taken
  initial begin : result_sink
    int            stall;
    pixel_result_t got;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = receiver_burst ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.pixel_x       = pixel_x;
      got.pixel_y       = pixel_y;
      got.red_out       = red_out;
      got.green_out     = green_out;
      got.blue_out      = blue_out;
      got.site_found    = site_found;
      got.nearest_index = nearest_index;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    logic [COUNT_W-1:0] count_plan [12];
    int                 p;
    int                 i;
    sb               = new();
    count_plan       = '{7'd64, 7'd127, 7'd0, 7'd65, 7'd1, 7'd2, 7'd3, 7'd100,
                         7'd64, 7'd127, 7'd0, 7'd0};
    sent_loads       = 0;
    sent_queries     = 0;
    count_settings   = 0;
    sender_burst     = 1'b0;
    receiver_burst   = 1'b0;
    rst              = 1'b1;
    site_count_we    = 1'b0;
    site_count_wdata = '0;
    in_valid         = 1'b0;
    func             = FUNC_LOAD;
    site_index       = '0;
    coord_x          = '0;
    coord_y          = '0;
    red_in           = '0;
    green_in         = '0;
    blue_in          = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // no sites in use: queries come back empty but still echo the pixel
    set_site_count(7'd0);
    send_word(make_query('0, '0));
    send_word(make_query(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX)));

    // corners plus a duplicated site and a symmetric pair for the tie rule;
    // the top entry is loaded too but stays outside the search
    send_word(make_load(6'd0, '0, '0, 8'h00, 8'h00, 8'h00));
    send_word(make_load(6'd1, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), 8'hff, 8'hff, 8'hff));
    send_word(make_load(6'd2, 10'd100, 10'd100, 8'ha5, 8'h5a, 8'hc3));
    send_word(make_load(6'd3, 10'd100, 10'd100, 8'h3c, 8'hc3, 8'h5a));
    send_word(make_load(6'd4, 10'd200, 10'd100, 8'h12, 8'h34, 8'h56));
    send_word(make_load(6'd63, COORD_W'(COORD_MAX), '0, 8'h80, 8'h01, 8'hfe));
    set_site_count(7'd5);
    send_word(make_query('0, '0));
    send_word(make_query(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX)));
    send_word(make_query(10'd100, 10'd100));   // two sites at zero distance
    send_word(make_query(10'd150, 10'd100));   // equidistant from both sides
    send_word(make_query(COORD_W'(COORD_MAX), '0));
    send_word(make_query('0, COORD_W'(COORD_MAX)));
    // overwrite an active entry and query it right behind the load
    send_word(make_load(6'd0, '0, '0, 8'h01, 8'h80, 8'h7f));
    send_word(make_query(10'd1, 10'd1));
    // a single site wins everything, even far away
    set_site_count(7'd1);
    send_word(make_query(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX)));

    // fill the whole table, each coordinate picking the crowded patch by a coin flip
    sender_burst = ($urandom_range(0, 1) != 0);
    for (i = 0; i < MAX_SITES; i++) begin
      send_word(make_load(IDX_W'(i), pick_coord($urandom_range(0, 1) != 0),
                          pick_coord($urandom_range(0, 1) != 0), CHAN_W'($urandom),
                          CHAN_W'($urandom), CHAN_W'($urandom)));
    end

    // random phases over many counts, beyond the table size included
    for (p = 0; p < 12; p++) begin
      if (p >= 10) count_plan[p] = COUNT_W'($urandom_range(0, 127));
      run_phase(count_plan[p], p[0]);
    end

    // tail: everything owed comes back, then watch for stray words
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d site loads and %0d pixel queries over %0d site-count settings",
             sent_loads, sent_queries, count_settings);
    $display("%0d pixel colors checked, %0d of them with no active site",
             sb.results_seen, sb.empty_results);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/nspc_pkg.sv
rtl/core/nspc_cell.sv
rtl/core/nearest_site_pixel_color_core.sv
test/tb_nearest_site_pixel_color_core.sv
